// ===== src/htd_pkg.sv =====
// shared types and constants for the header/trailer deframer
// no dependencies; used by header_trailer_deframer_top
package htd_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int SLOT_W       = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int BYTE_W       = 8;

    // item codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_RELOAD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER_SECOND = 3'd4;

    // register reset values
    localparam logic [BYTE_W-1:0] TIMEOUT_RELOAD_RST = 8'd2;
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST   = 8'hA5;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST  = 8'h5A;
    localparam logic [BYTE_W-1:0] TRAILER_FIRST_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] TRAILER_SECOND_RST = 8'hAA;

    // first frame slot follows the two header bytes
    localparam logic [IDX_W-1:0] FRAME_START = IDX_W'(2);

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic              in_payload;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] stored_byte;
        logic              header_seen;
        logic              frame_end;
    } out_word_t;

    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(BUFFER_DEPTH - 1))
            r = '0;
        else
            r = i + IDX_W'(1);
        return r;
    endfunction

endpackage

// ===== src/header_trailer_deframer_top.sv =====
// header/trailer deframer: hunts for a two-byte header, numbers frame bytes,
// closes on a two-byte trailer, abandons on idle timeout; uses htd_pkg
// a byte's result is registered, in the output register or, if that is held, the skid entry
// throughput: one word per cycle while in_stall is low, bytes and ticks alike; a two-entry output
// register (result plus skid) lets input flow while a result waits
// in_stall rises only when both output entries are full
// reset (rst_n, async, active low) restores register defaults, clears timeout,
// hunt state and framing, sets frame index to 2 and empties the output
module header_trailer_deframer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  htd_pkg::in_word_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output htd_pkg::out_word_t             out_data,
    input  logic                           cfg_we,
    input  logic [htd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [htd_pkg::BYTE_W-1:0]     cfg_wdata
);

    logic [htd_pkg::BYTE_W-1:0] timeout_reload_reg;
    logic [htd_pkg::BYTE_W-1:0] header_first_reg;
    logic [htd_pkg::BYTE_W-1:0] header_second_reg;
    logic [htd_pkg::BYTE_W-1:0] trailer_first_reg;
    logic [htd_pkg::BYTE_W-1:0] trailer_second_reg;

    logic [htd_pkg::BYTE_W-1:0] idle_left_reg,       idle_left_next;
    logic [htd_pkg::IDX_W-1:0]  hunt_index_reg,      hunt_index_next;
    logic [htd_pkg::BYTE_W-1:0] hunt_slot0_reg,      hunt_slot0_next;
    logic [htd_pkg::BYTE_W-1:0] hunt_slot1_reg,      hunt_slot1_next;
    logic                       framing_reg,         framing_next;
    logic [htd_pkg::IDX_W-1:0]  frame_index_reg,     frame_index_next;
    logic [htd_pkg::BYTE_W-1:0] last_frame_byte_reg, last_frame_byte_next;

    htd_pkg::out_word_t result;
    htd_pkg::out_word_t out_word_reg;
    htd_pkg::out_word_t skid_word_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;

    logic in_fire;
    logic out_fire;
    logic produce;
    logic done;
    logic hit;

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;
    assign produce  = in_fire && (in_data.op == htd_pkg::OP_BYTE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reload_reg <= htd_pkg::TIMEOUT_RELOAD_RST;
            header_first_reg   <= htd_pkg::HEADER_FIRST_RST;
            header_second_reg  <= htd_pkg::HEADER_SECOND_RST;
            trailer_first_reg  <= htd_pkg::TRAILER_FIRST_RST;
            trailer_second_reg <= htd_pkg::TRAILER_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                htd_pkg::REG_TIMEOUT_RELOAD: timeout_reload_reg <= cfg_wdata;
                htd_pkg::REG_HEADER_FIRST:   header_first_reg   <= cfg_wdata;
                htd_pkg::REG_HEADER_SECOND:  header_second_reg  <= cfg_wdata;
                htd_pkg::REG_TRAILER_FIRST:  trailer_first_reg  <= cfg_wdata;
                htd_pkg::REG_TRAILER_SECOND: trailer_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-item state update and result
    always_comb
    begin
        idle_left_next       = idle_left_reg;
        hunt_index_next      = hunt_index_reg;
        hunt_slot0_next      = hunt_slot0_reg;
        hunt_slot1_next      = hunt_slot1_reg;
        framing_next         = framing_reg;
        frame_index_next     = frame_index_reg;
        last_frame_byte_next = last_frame_byte_reg;
        done                 = 1'b0;
        hit                  = 1'b0;

        result.in_payload  = framing_reg;
        result.stored_byte = in_data.rx_byte;
        result.header_seen = 1'b0;
        result.frame_end   = 1'b0;
        result.slot        = framing_reg ? htd_pkg::SLOT_W'(frame_index_reg)
                                         : htd_pkg::SLOT_W'(hunt_index_reg);

        if (in_fire)
        begin
            if (in_data.op == htd_pkg::OP_TICK)
            begin
                if (idle_left_reg != '0)
                    idle_left_next = idle_left_reg - 8'd1;
                else
                begin
                    // idle too long: drop back to hunting
                    hunt_index_next  = '0;
                    framing_next     = 1'b0;
                    frame_index_next = htd_pkg::FRAME_START;
                end
            end
            else
            begin
                idle_left_next = timeout_reload_reg;
                if (framing_reg)
                begin
                    done = (last_frame_byte_reg == trailer_first_reg)
                        && (in_data.rx_byte == trailer_second_reg);
                    result.frame_end     = done;
                    last_frame_byte_next = in_data.rx_byte;
                    if (done)
                    begin
                        framing_next     = 1'b0;
                        frame_index_next = htd_pkg::FRAME_START;
                    end
                    else
                        frame_index_next = htd_pkg::next_index(frame_index_reg);
                end
                else
                begin
                    if (hunt_index_reg == '0)
                        hunt_slot0_next = in_data.rx_byte;
                    else if (hunt_index_reg == htd_pkg::IDX_W'(1))
                        hunt_slot1_next = in_data.rx_byte;
                    hunt_index_next = htd_pkg::next_index(hunt_index_reg);
                    hit = (hunt_slot0_next == header_first_reg)
                       && (hunt_slot1_next == header_second_reg);
                    result.header_seen = hit;
                    if (hit)
                    begin
                        // slot 1 stays stale on purpose
                        framing_next         = 1'b1;
                        hunt_index_next      = '0;
                        hunt_slot0_next      = '0;
                        last_frame_byte_next = header_second_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_left_reg       <= '0;
            hunt_index_reg      <= '0;
            hunt_slot0_reg      <= '0;
            hunt_slot1_reg      <= '0;
            framing_reg         <= 1'b0;
            frame_index_reg     <= htd_pkg::FRAME_START;
            last_frame_byte_reg <= htd_pkg::HEADER_SECOND_RST;
        end
        else
        begin
            idle_left_reg       <= idle_left_next;
            hunt_index_reg      <= hunt_index_next;
            hunt_slot0_reg      <= hunt_slot0_next;
            hunt_slot1_reg      <= hunt_slot1_next;
            framing_reg         <= framing_next;
            frame_index_reg     <= frame_index_next;
            last_frame_byte_reg <= last_frame_byte_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (produce)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_word_reg <= skid_word_reg;
        end
        else if (produce)
        begin
            if (!out_valid_reg || out_fire)
                out_word_reg <= result;
            else
                skid_word_reg <= result;
        end
    end

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for header_trailer_deframer_top: random and directed byte/tick traffic
// checked word by word against a deframer state model kept in this file; depends on htd_pkg
`timescale 1ns / 100ps

module tb;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    htd_pkg::in_word_t             in_data;
    logic                          out_valid;
    logic                          out_stall;
    htd_pkg::out_word_t            out_data;
    logic                          cfg_we;
    logic [htd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [htd_pkg::BYTE_W-1:0]    cfg_wdata;

    // register copies
    logic [htd_pkg::BYTE_W-1:0]  cfg_reload = htd_pkg::TIMEOUT_RELOAD_RST;
    logic [htd_pkg::BYTE_W-1:0]  cfg_hdr1   = htd_pkg::HEADER_FIRST_RST;
    logic [htd_pkg::BYTE_W-1:0]  cfg_hdr2   = htd_pkg::HEADER_SECOND_RST;
    logic [htd_pkg::BYTE_W-1:0]  cfg_trl1   = htd_pkg::TRAILER_FIRST_RST;
    logic [htd_pkg::BYTE_W-1:0]  cfg_trl2   = htd_pkg::TRAILER_SECOND_RST;

    // deframer state
    logic [htd_pkg::BYTE_W-1:0]  idle_cnt  = '0;
    logic [htd_pkg::IDX_W-1:0]   hunt_idx  = '0;
    logic [htd_pkg::BYTE_W-1:0]  hunt_b0   = '0;
    logic [htd_pkg::BYTE_W-1:0]  hunt_b1   = '0;
    logic                        in_frame  = 1'b0;
    logic [htd_pkg::IDX_W-1:0]   frame_idx = htd_pkg::FRAME_START;
    logic [htd_pkg::BYTE_W-1:0]  prev_byte = htd_pkg::HEADER_SECOND_RST;

    htd_pkg::out_word_t expected_words[$];
    int                 fail_count = 0;
    int                 items_sent = 0;
    bit                 gaps_on = 1'b1;
    bit                 stalls_on = 1'b1;

    header_trailer_deframer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [htd_pkg::IDX_W-1:0] advance_index(
        input logic [htd_pkg::IDX_W-1:0] idx);
        logic [htd_pkg::IDX_W-1:0] nxt;
        if (idx == htd_pkg::IDX_W'(htd_pkg::BUFFER_DEPTH - 1))
            nxt = '0;
        else
            nxt = idx + 1'b1;
        return nxt;
    endfunction

    // update the deframer state for one accepted word, queue the result it causes
    function automatic void deframe_word(input htd_pkg::in_word_t w);
        htd_pkg::out_word_t r;
        if (w.op == htd_pkg::OP_TICK)
        begin
            if (idle_cnt != 0)
                idle_cnt = idle_cnt - 1'b1;
            else
            begin
                hunt_idx  = '0;
                in_frame  = 1'b0;
                frame_idx = htd_pkg::FRAME_START;
            end
            return;
        end
        idle_cnt = cfg_reload;
        r = '0;
        r.stored_byte = w.rx_byte;
        if (in_frame)
        begin
            r.in_payload = 1'b1;
            r.slot       = htd_pkg::SLOT_W'(frame_idx);
            r.frame_end  = (prev_byte == cfg_trl1) && (w.rx_byte == cfg_trl2);
            prev_byte    = w.rx_byte;
            if (r.frame_end)
            begin
                in_frame  = 1'b0;
                frame_idx = htd_pkg::FRAME_START;
            end
            else
                frame_idx = advance_index(frame_idx);
        end
        else
        begin
            r.slot = htd_pkg::SLOT_W'(hunt_idx);
            if (hunt_idx == 0)
                hunt_b0 = w.rx_byte;
            else if (hunt_idx == 1)
                hunt_b1 = w.rx_byte;
            hunt_idx = advance_index(hunt_idx);
            // position 1 stays stale after a hit
            r.header_seen = (hunt_b0 == cfg_hdr1) && (hunt_b1 == cfg_hdr2);
            if (r.header_seen)
            begin
                in_frame  = 1'b1;
                hunt_idx  = '0;
                hunt_b0   = '0;
                prev_byte = cfg_hdr2;
            end
        end
        expected_words.push_back(r);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        htd_pkg::out_word_t want;
        if (rst_n === 1'b1 && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t ns: unexpected word, expected none, actual 0x%0h", $time, out_data);
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("in_payload", 32'(want.in_payload), 32'(out_data.in_payload));
                check_field("slot", 32'(want.slot), 32'(out_data.slot));
                check_field("stored_byte", 32'(want.stored_byte), 32'(out_data.stored_byte));
                check_field("header_seen", 32'(want.header_seen), 32'(out_data.header_seen));
                check_field("frame_end", 32'(want.frame_end), 32'(out_data.frame_end));
            end
        end
    end

    // output side: per word hold-off, then wait for a word
    initial
    begin : result_stall
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = stalls_on ? $urandom_range(0, 18) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_word(input htd_pkg::in_word_t w);
        int gap;
        gap = gaps_on ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        deframe_word(w);
        items_sent++;
    endtask

    task automatic send_byte(input logic [htd_pkg::BYTE_W-1:0] b);
        htd_pkg::in_word_t w;
        w.op      = htd_pkg::OP_BYTE;
        w.rx_byte = b;
        send_word(w);
    endtask

    task automatic send_tick();
        htd_pkg::in_word_t w;
        w.op      = htd_pkg::OP_TICK;
        w.rx_byte = htd_pkg::BYTE_W'($urandom);
        send_word(w);
    endtask

    // enough ticks to expire the timeout and restart the hunt at position 0
    task automatic drop_to_hunt();
        repeat (idle_cnt + 1) send_tick();
    endtask

    // ticks make no word, so leave room for the block to settle
    task automatic quiesce();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [htd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [htd_pkg::BYTE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            htd_pkg::REG_TIMEOUT_RELOAD: cfg_reload = val;
            htd_pkg::REG_HEADER_FIRST:   cfg_hdr1 = val;
            htd_pkg::REG_HEADER_SECOND:  cfg_hdr2 = val;
            htd_pkg::REG_TRAILER_FIRST:  cfg_trl1 = val;
            htd_pkg::REG_TRAILER_SECOND: cfg_trl2 = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [htd_pkg::BYTE_W-1:0] reload, h1, h2, t1, t2);
        write_reg(htd_pkg::REG_TIMEOUT_RELOAD, reload);
        write_reg(htd_pkg::REG_HEADER_FIRST, h1);
        write_reg(htd_pkg::REG_HEADER_SECOND, h2);
        write_reg(htd_pkg::REG_TRAILER_FIRST, t1);
        write_reg(htd_pkg::REG_TRAILER_SECOND, t2);
        // indexes past the last register must have no effect
        for (int i = int'(htd_pkg::REG_TRAILER_SECOND) + 1; i < 2 ** htd_pkg::CFG_IDX_W; i++)
            write_reg(htd_pkg::CFG_IDX_W'(i), htd_pkg::BYTE_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame();
        int len;
        if (!in_frame && hunt_idx != 0 && (idle_cnt < 20 || $urandom_range(0, 7) == 0))
            drop_to_hunt();
        send_byte(cfg_hdr1);
        send_byte(cfg_hdr2);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 8);
        repeat (len)
        begin
            // ticks no more than the reload keep the frame alive
            if (cfg_reload != 0 && $urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, (cfg_reload > 4) ? 4 : cfg_reload)) send_tick();
            send_byte(htd_pkg::BYTE_W'($urandom));
        end
        if ($urandom_range(0, 7) != 0)
        begin
            send_byte(cfg_trl1);
            send_byte(cfg_trl2);
        end
    endtask

    task automatic run_traffic(input int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 15) == 0)
                gaps_on = !gaps_on;
            if ($urandom_range(0, 15) == 0)
                stalls_on = !stalls_on;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_frame();
                6: repeat ($urandom_range(1, 5)) send_byte(htd_pkg::BYTE_W'($urandom));
                7: repeat ($urandom_range(1, (cfg_reload < 12) ? cfg_reload + 2 : 12))
                       send_tick();
                8:
                begin
                    // header broken after its first byte
                    send_byte(cfg_hdr1);
                    send_byte(htd_pkg::BYTE_W'($urandom));
                end
                default: send_byte(cfg_hdr1);
            endcase
        end
    endtask

    task automatic test_directed();
        send_tick();                             // expiry with the timeout already at zero
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(htd_pkg::HEADER_FIRST_RST);    // past position 1, ignored by the detector
        repeat (3) send_tick();
        send_byte(htd_pkg::HEADER_FIRST_RST);
        send_byte(htd_pkg::HEADER_SECOND_RST);
        send_byte(8'hFF);
        send_byte(htd_pkg::TRAILER_FIRST_RST);
        send_byte(8'h00);
        send_byte(htd_pkg::TRAILER_FIRST_RST);
        send_byte(htd_pkg::TRAILER_SECOND_RST);
        send_byte(htd_pkg::HEADER_FIRST_RST);    // stale second header slot opens a frame alone
        send_byte(8'h00);
        repeat (2) send_tick();
        send_byte(8'h80);
        repeat (4) send_tick();                  // expires inside the frame, then repeats at zero
        send_byte(htd_pkg::TRAILER_FIRST_RST);
        send_byte(htd_pkg::TRAILER_SECOND_RST);
    endtask

    task automatic test_index_wrap();
        drop_to_hunt();
        repeat (70) send_byte(htd_pkg::BYTE_W'($urandom));
        drop_to_hunt();
        send_byte(cfg_hdr1);
        send_byte(cfg_hdr2);
        repeat (70) send_byte(htd_pkg::BYTE_W'($urandom));
        send_byte(cfg_trl1);
        send_byte(cfg_trl2);
    endtask

    task automatic test_register_extremes();
        quiesce();
        set_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        run_traffic(100);
        quiesce();
        set_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_traffic(100);
    endtask

    task automatic test_header_equals_trailer();
        logic [htd_pkg::BYTE_W-1:0] a, b;
        a = htd_pkg::BYTE_W'($urandom);
        b = htd_pkg::BYTE_W'($urandom);
        quiesce();
        set_regs(8'd1, a, b, a, b);
        run_traffic(100);
    endtask

    task automatic test_random_settings();
        repeat (3)
        begin
            quiesce();
            set_regs(htd_pkg::BYTE_W'($urandom_range(0, 6)), htd_pkg::BYTE_W'($urandom),
                     htd_pkg::BYTE_W'($urandom), htd_pkg::BYTE_W'($urandom),
                     htd_pkg::BYTE_W'($urandom));
            run_traffic(70);
        end
    endtask

    initial
    begin : main
        int waited;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_index_wrap();
        run_traffic(120);
        test_register_extremes();
        test_header_equals_trailer();
        test_random_settings();

        in_valid <= 1'b0;
        waited = 0;
        while (expected_words.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $display("%0t ns: %0d words never arrived", $time, expected_words.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/htd_pkg.sv
src/header_trailer_deframer_top.sv
tb/tb.sv
